[rtl/stbp_pkg.sv]
`default_nettype none

package stbp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPacketType = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxChars = 2'd1;

  localparam logic [7:0] PacketTypeReset = 8'd35;
  localparam logic [6:0] MaxCharsReset = 7'd80;

  localparam logic [7:0] LowPrintable = 8'd32;
  localparam logic [7:0] HighPrintable = 8'd126;
  localparam logic [6:0] SpaceCode = 7'd32;

  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       team_flag;
    logic       first_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
  } out_t;

  // One accepted character turns into up to three bytes of packet.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;
    logic            eop;
  } entry_t;

endpackage

`default_nettype wire

[rtl/stbp_front.sv]
`default_nettype none

module stbp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      packet_type_i,
  input  wire logic [6:0]      max_chars_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire stbp_pkg::in_t   in_data_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output stbp_pkg::entry_t     q_entry_o
);
  import stbp_pkg::*;

  logic [6:0] pending_bits_q, pending_bits_d;
  logic [2:0] pending_count_q, pending_count_d;
  logic [6:0] chars_taken_q, chars_taken_d;

  logic        accept;
  logic [6:0]  chars_base;
  logic        take;
  logic [6:0]  ch7;
  logic [23:0] acc;
  logic [4:0]  cnt;
  logic [1:0]  nfull;
  logic [1:0]  num;
  logic [6:0]  rest;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    chars_base = in_data_i.first_char ? 7'd0 : chars_taken_q;
    take = chars_base < max_chars_i;
    if (in_data_i.char_code < LowPrintable || in_data_i.char_code > HighPrintable) begin
      ch7 = SpaceCode;
    end else begin
      ch7 = in_data_i.char_code[6:0];
    end

    acc = '0;
    if (in_data_i.first_char) begin
      acc[8:0] = {in_data_i.team_flag, packet_type_i};
      cnt = 5'd9;
    end else begin
      acc[6:0] = pending_bits_q;
      cnt = {2'b00, pending_count_q};
    end
    if (take) begin
      acc = acc | ({17'd0, ch7} << cnt);
      cnt = cnt + 5'd7;
    end
    // The terminator is all zeros, so only the bit count moves.
    if (in_data_i.last_char) begin
      cnt = cnt + 5'd7;
    end

    nfull = cnt[4:3];
    num = nfull + {1'b0, (in_data_i.last_char && (cnt[2:0] != 3'd0))};

    unique case (nfull)
      2'd0:    rest = acc[6:0];
      2'd1:    rest = acc[14:8];
      default: rest = acc[22:16];
    endcase

    if (in_data_i.last_char) begin
      pending_bits_d = '0;
      pending_count_d = '0;
      chars_taken_d = '0;
    end else begin
      pending_bits_d = rest;
      pending_count_d = cnt[2:0];
      chars_taken_d = take ? chars_base + 7'd1 : chars_base;
    end
  end

  assign q_push_o = accept && (num != 2'd0);
  assign q_entry_o.bytes = {acc[23:16], acc[15:8], acc[7:0]};
  assign q_entry_o.num = num;
  assign q_entry_o.eop = in_data_i.last_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bits_q <= '0;
      pending_count_q <= '0;
      chars_taken_q <= '0;
    end else if (accept) begin
      pending_bits_q <= pending_bits_d;
      pending_count_q <= pending_count_d;
      chars_taken_q <= chars_taken_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_char |-> q_push_o && q_entry_o.eop)
    else $error("last character did not close a packet");
  a_pending_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_char |=> pending_count_q == 3'd0 && chars_taken_q == 7'd0)
    else $error("state not cleared after last character");
`endif

endmodule

`default_nettype wire

[rtl/stbp_queue.sv]
`default_nettype none

module stbp_queue #(
  parameter int unsigned Depth = stbp_pkg::QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire stbp_pkg::entry_t entry_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output stbp_pkg::entry_t      head_o
);
  import stbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

[rtl/stbp_back.sv]
`default_nettype none

module stbp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire stbp_pkg::entry_t q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output stbp_pkg::out_t        out_data_o
);
  import stbp_pkg::*;

  logic       out_valid_q;
  out_t       out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       at_end;

  // The output register reloads whenever the queue holds an entry and the register is empty or being drained.
  assign load = !q_empty_i && (!out_valid_q || out_ready_i);
  assign at_end = (idx_q == q_head_i.num - 2'd1);
  assign q_pop_o = load && at_end;

  always_comb begin
    unique case (idx_q)
      2'd0:    out_d.out_byte = q_head_i.bytes[0];
      2'd1:    out_d.out_byte = q_head_i.bytes[1];
      default: out_d.out_byte = q_head_i.bytes[2];
    endcase
    out_d.end_of_packet = q_head_i.eop && at_end;
    if (!load) begin
      idx_d = idx_q;
    end else if (at_end) begin
      idx_d = '0;
    end else begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  a_eop_ends_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_d.end_of_packet |-> q_pop_o)
    else $error("end of packet inside a queue entry");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> idx_q < q_head_i.num)
    else $error("byte index beyond entry");
`endif

endmodule

`default_nettype wire

[rtl/seven_bit_text_packer_core.sv]
`default_nettype none

// Packs a chat message, one character per request, into a stream of bytes, LSB first.
// A request with first_char set opens a packet with the 8-bit packet type and the team
// flag; each character then adds 7 bits (codes outside 32..126 become a space) until
// max_chars characters have been taken, and last_char appends a 7-bit zero terminator,
// flushes the partial byte with zero padding and marks the final byte end_of_packet.
// The front stage takes one character per cycle while the queue is not full and turns it
// into zero to three bytes; a small queue holds these, and the output register sends one
// byte per cycle while the receiver is ready, so new characters can be taken while the
// bytes of earlier ones are still going out. The configuration port is always ready
// and should be written only while no message is in flight.
module seven_bit_text_packer_core #(
  parameter int unsigned QueueDepth = stbp_pkg::QueueDepthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [stbp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [stbp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire stbp_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output stbp_pkg::out_t                        out_data_o
);
  import stbp_pkg::*;

  logic [7:0] packet_type_q;
  logic [6:0] max_chars_q;

  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_entry;
  entry_t q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_type_q <= PacketTypeReset;
      max_chars_q <= MaxCharsReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgPacketType) begin
        packet_type_q <= cfg_data_i;
      end else if (cfg_index_i == CfgMaxChars) begin
        max_chars_q <= cfg_data_i[6:0];
      end
    end
  end

  stbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .packet_type_i (packet_type_q),
    .max_chars_i   (max_chars_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_entry)
  );

  stbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  stbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/tb_seven_bit_text_packer_core.sv]
`timescale 1ns / 100ps

module tb_seven_bit_text_packer_core;
  import stbp_pkg::*;

  localparam int CharTarget = 320;
  localparam int QuietCycles = 16;
  localparam int StuckLimit = 2000;
  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  typedef enum logic {
    ROW_CHAR,
    ROW_CFG
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_HICCUP
  } rx_mode_e;

  typedef struct packed {
    row_kind_e            kind;
    in_t                  item;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  val;
    logic                 typed;
    logic [1:0]           n;
    out_t [2:0]           res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  // Packer state as the block should hold it.
  logic [7:0] pk_type = PacketTypeReset;
  logic [6:0] pk_max = MaxCharsReset;
  logic [6:0] pk_bits = '0;
  logic [2:0] pk_count = '0;
  logic [6:0] pk_taken = '0;

  out_t     packet_bytes_due[$];
  stim_row_t script[$];
  int       errors = 0;
  int       chars_sent = 0;
  int       burst_left = 0;
  int       stuck_cycles = 0;
  int       rx_cycle = 0;
  rx_mode_e rx_mode = RX_OPEN;

  seven_bit_text_packer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pack_char(input in_t c, output out_t [2:0] res);
    logic [31:0] acc;
    int          cnt;
    int          n;
    logic [6:0]  code;
    res = '0;
    n = 0;
    if (c.first_char) begin
      pk_bits = '0;
      pk_count = '0;
      pk_taken = '0;
    end
    acc = 32'(pk_bits);
    cnt = int'(pk_count);
    if (c.first_char) begin
      acc |= 32'(pk_type) << cnt;
      cnt += 8;
      acc |= 32'(c.team_flag) << cnt;
      cnt += 1;
    end
    if (pk_taken < pk_max) begin
      if (c.char_code < LowPrintable || c.char_code > HighPrintable) begin
        code = SpaceCode;
      end else begin
        code = c.char_code[6:0];
      end
      acc |= 32'(code) << cnt;
      cnt += 7;
      pk_taken = pk_taken + 7'd1;
    end
    if (c.last_char) begin
      cnt += 7;
    end
    while (cnt >= 8) begin
      res[n] = '{out_byte: acc[7:0], end_of_packet: 1'b0};
      acc = acc >> 8;
      cnt -= 8;
      n++;
    end
    if (c.last_char) begin
      // A terminator that lands on a byte boundary marks the last full byte instead.
      if (cnt > 0) begin
        res[n] = '{out_byte: acc[7:0], end_of_packet: 1'b1};
        n++;
      end else if (n > 0) begin
        res[n-1].end_of_packet = 1'b1;
      end
      pk_bits = '0;
      pk_count = '0;
      pk_taken = '0;
    end else begin
      pk_bits = acc[6:0];
      pk_count = cnt[2:0];
    end
    return n;
  endfunction

  function automatic stim_row_t char_row(logic [7:0] ch, logic team, logic first, logic last);
    stim_row_t r = '0;
    r.kind = ROW_CHAR;
    r.item = '{char_code: ch, team_flag: team, first_char: first, last_char: last};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    stim_row_t r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t known(stim_row_t r, logic [1:0] n, out_t o0, out_t o1,
                                      out_t o2);
    stim_row_t k = r;
    k.typed = 1'b1;
    k.n = n;
    k.res = {o2, o1, o0};
    return k;
  endfunction

  task automatic send_char(input stim_row_t r);
    out_t [2:0] res;
    int         n;
    cfg_valid_i <= 1'b0;
    in_data_i <= r.item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = pack_char(r.item, res);
    if (r.typed) begin
      n = int'(r.n);
      res = r.res;
    end
    for (int k = 0; k < n; k++) begin
      packet_bytes_due.push_back(res[k]);
    end
    chars_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgPacketType: pk_type = val;
      CfgMaxChars: pk_max = val[6:0];
      default: ;
    endcase
  endtask

  // Drops both request channels and waits until the block has nothing left in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (packet_bytes_due.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : rx_side
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (packet_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte %02h eop %0b", $time, out_data_o.out_byte,
                 out_data_o.end_of_packet);
        errors++;
      end else begin
        want = packet_bytes_due.pop_front();
        if (out_data_o.out_byte !== want.out_byte ||
            out_data_o.end_of_packet !== want.end_of_packet) begin
          $display("%0t: expected byte %02h eop %0b, got byte %02h eop %0b", $time,
                   want.out_byte, want.end_of_packet, out_data_o.out_byte,
                   out_data_o.end_of_packet);
          errors++;
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 50 == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN: out_ready_i <= 1'b1;
      RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= (rx_cycle % 5 == 0);
      default: out_ready_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("seven_bit_text_packer_core verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int          pick;
    int          msg_len;
    logic [7:0]  code;
    logic [7:0]  mc;
    bit          long_done;
    long_done = 1'b0;

    // After reset, with no first mark: the character goes out with no header.
    script.push_back(known(char_row(8'h41, 1'b0, 1'b0, 1'b0), 2'd0, '0, '0, '0));
    script.push_back(known(char_row(8'h7F, 1'b1, 1'b0, 1'b0), 2'd1, {8'h41, 1'b0}, '0, '0));
    script.push_back(known(char_row(8'h00, 1'b0, 1'b0, 1'b1), 2'd3, {8'h10, 1'b0},
                           {8'h08, 1'b0}, {8'h00, 1'b1}));
    // First and last on one item, reset packet type.
    script.push_back(known(char_row(8'h7E, 1'b1, 1'b1, 1'b1), 2'd3, {8'h23, 1'b0},
                           {8'hFD, 1'b0}, {8'h00, 1'b1}));
    // Eight characters: the terminator ends exactly on a byte boundary.
    script.push_back(char_row(8'h48, 1'b0, 1'b1, 1'b0));
    script.push_back(char_row(8'h1F, 1'b1, 1'b0, 1'b0));
    script.push_back(char_row(8'h20, 1'b0, 1'b0, 1'b0));
    script.push_back(char_row(8'h80, 1'b1, 1'b0, 1'b0));
    script.push_back(char_row(8'hFF, 1'b0, 1'b0, 1'b0));
    script.push_back(char_row(8'h7E, 1'b0, 1'b0, 1'b0));
    script.push_back(char_row(8'h61, 1'b1, 1'b0, 1'b0));
    script.push_back(char_row(8'h5A, 1'b0, 1'b0, 1'b1));
    // A second first mark in the middle of a message restarts the packet.
    script.push_back(char_row(8'h31, 1'b1, 1'b1, 1'b0));
    script.push_back(char_row(8'h32, 1'b0, 1'b1, 1'b0));
    script.push_back(char_row(8'h33, 1'b0, 1'b0, 1'b0));
    script.push_back(char_row(8'h34, 1'b1, 1'b0, 1'b1));
    // Limit of one: later characters are dropped, the last one still terminates.
    script.push_back(cfg_row(CfgMaxChars, 8'd1));
    script.push_back(cfg_row(CfgPacketType, 8'd0));
    script.push_back(char_row(8'h41, 1'b1, 1'b1, 1'b0));
    script.push_back(char_row(8'h42, 1'b0, 1'b0, 1'b0));
    script.push_back(char_row(8'h43, 1'b0, 1'b0, 1'b1));
    // Limit of zero: only header, team flag and terminator remain.
    script.push_back(cfg_row(CfgMaxChars, 8'd0));
    script.push_back(char_row(8'h41, 1'b0, 1'b1, 1'b1));
    script.push_back(cfg_row(CfgPacketType, 8'hFF));
    script.push_back(cfg_row(CfgMaxChars, 8'hFF));
    script.push_back(cfg_row(CfgSpareIdx, 8'hA5));
    script.push_back(char_row(8'hFF, 1'b0, 1'b1, 1'b1));
    script.push_back(char_row(8'h20, 1'b1, 1'b1, 1'b0));
    script.push_back(char_row(8'h7E, 1'b0, 1'b0, 1'b1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_char(script[i]);
      end
    end

    while (chars_sent < CharTarget) begin
      pick = $urandom_range(0, 99);
      msg_len = 0;
      if (!long_done && chars_sent > 120) begin
        // One message that runs past the widest limit.
        settle();
        write_reg(CfgMaxChars, 8'd127);
        long_done = 1'b1;
        msg_len = $urandom_range(128, 135);
      end else if (pick < 8) begin
        settle();
        write_reg(CfgPacketType, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: mc = 8'd1;
          1: mc = 8'hFF;
          2: mc = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 6))};
          default: mc = 8'($urandom_range(1, 127));
        endcase
        write_reg(CfgMaxChars, mc);
        if ($urandom_range(0, 3) == 0) begin
          write_reg(CfgSpareIdx, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 82) begin
        msg_len = $urandom_range(1, 10);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_char(char_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
        end
      end
      for (int k = 0; k < msg_len; k++) begin
        code = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(32, 126))
                                             : 8'($urandom_range(0, 255));
        send_char(char_row(code, 1'($urandom_range(0, 1)), k == 0, k == msg_len - 1));
      end
    end

    settle();
    if (errors == 0) begin
      $display("seven_bit_text_packer_core verification clean");
    end else begin
      $display("seven_bit_text_packer_core verification failed");
    end
    $finish;
  end

endmodule
